/* design/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants for the touch sample to screen point core
// Field widths, register indexes, status codes and default geometry.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // raw converter sample width and derived field widths
  localparam int SAMPLE_W   = 12;
  localparam int PRESSURE_W = 13;
  localparam int COORD_W    = 12;
  localparam int GAIN_W     = 24;
  localparam int OFFSET_W   = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // stream payload widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  // pressure = z1 + Z_FULL_SCALE - z2
  localparam logic [PRESSURE_W-1:0] Z_FULL_SCALE      = 13'd4095;
  localparam logic [PRESSURE_W-1:0] THRESHOLD_DEFAULT = 13'd400;

  // default geometry and fixed point format
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;
  localparam int FRACTION_BITS_DEF = 16;

  // result status codes
  typedef enum logic [1:0] {
    ST_NO_CAL      = 2'd0,
    ST_NOT_PRESSED = 2'd1,
    ST_TOO_LIGHT   = 2'd2,
    ST_VALID       = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_X_RX  = 3'd0,
    REG_GAIN_X_RY  = 3'd1,
    REG_OFFSET_X   = 3'd2,
    REG_GAIN_Y_RX  = 3'd3,
    REG_GAIN_Y_RY  = 3'd4,
    REG_OFFSET_Y   = 3'd5,
    REG_CAL_VALID  = 3'd6,
    REG_THRESHOLD  = 3'd7
  } reg_idx_t;

endpackage

/* design/tsp_axis_map.sv */
// ----------------------------------------------------------------------------
// tsp_axis_map: affine map of one screen axis
// Registers the two gain products, then sums with the offset, rounds half
// away from zero and clamps to 0..LIMIT-1.
// ----------------------------------------------------------------------------
module tsp_axis_map #(
  parameter int LIMIT         = tsp_pkg::SCREEN_WIDTH_DEF,
  parameter int FRACTION_BITS = tsp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                prod_en,
  input  logic [tsp_pkg::SAMPLE_W-1:0]        raw_x,
  input  logic [tsp_pkg::SAMPLE_W-1:0]        raw_y,
  input  logic signed [tsp_pkg::GAIN_W-1:0]   gain_rx,
  input  logic signed [tsp_pkg::GAIN_W-1:0]   gain_ry,
  input  logic signed [tsp_pkg::OFFSET_W-1:0] offset,
  output logic [tsp_pkg::COORD_W-1:0]         coord
);

  localparam int PROD_W = tsp_pkg::GAIN_W + tsp_pkg::SAMPLE_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W + 1;
  localparam int Q_W    = RND_W - FRACTION_BITS;
  localparam logic [RND_W-1:0] HALF = RND_W'(1) << (FRACTION_BITS - 1);

  logic signed [PROD_W-1:0] prod_rx_r;
  logic signed [PROD_W-1:0] prod_ry_r;
  logic signed [ACC_W-1:0]  acc;
  logic [RND_W-1:0]         rnd;
  logic [Q_W-1:0]           quot;

  // multiply the averaged samples, zero extended to signed
  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_rx_r <= gain_rx * $signed({1'b0, raw_x});
      prod_ry_r <= gain_ry * $signed({1'b0, raw_y});
    end
  end

  // sum, round at the binary point, clamp to the screen
  always_comb begin
    acc  = ACC_W'(prod_rx_r) + ACC_W'(prod_ry_r) + ACC_W'(offset);
    rnd  = {1'b0, acc} + HALF;
    quot = rnd[RND_W-1:FRACTION_BITS];
    if (acc <= 0) begin
      coord = '0;
    end else if (quot > Q_W'(LIMIT - 1)) begin
      coord = tsp_pkg::COORD_W'(LIMIT - 1);
    end else begin
      coord = quot[tsp_pkg::COORD_W-1:0];
    end
  end

endmodule

/* design/touch_sample_to_screen_point_core.sv */
// ----------------------------------------------------------------------------
// touch_sample_to_screen_point_core: resistive touch gate and calibration map
// Turns one touch sample set into a status, a pressure and a screen point.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream carries one sample set per transfer: in_tuser is the pen IRQ
//         level, in_tdata the Z1, Z2, two X and two Y conversions.
//   out_* stream returns one result per sample set: out_tuser is the status,
//         out_tdata the pressure and the clamped screen column and row.
//   cfg_* writes one calibration register per cycle with cfg_we high; write
//         only while no sample set is in flight.
// The stages are an input stage (pressure gate, averaging), a product stage
// (four 24x13 multipliers) and the output register (sum, rounding, clamp).
// Throughput is one sample set per cycle while the receiver does not stall.
// A stalled receiver holds the output register; stages behind it keep
// filling until full, then in_tready drops. Reset empties the pipeline and
// loads the register defaults (threshold 400, no calibration loaded).
// ----------------------------------------------------------------------------
module touch_sample_to_screen_point_core #(
  parameter int SCREEN_WIDTH  = tsp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tsp_pkg::SCREEN_HEIGHT_DEF,
  parameter int FRACTION_BITS = tsp_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // z_first, z_second, x_sample_a, x_sample_b, y_sample_a, y_sample_b
  input  logic [tsp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // pen_irq_level
  input  logic                               in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pressure_value, screen_x, screen_y, zero pad
  output logic [tsp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status
  output logic [1:0]                         out_tuser,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [tsp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SW = tsp_pkg::SAMPLE_W;
  localparam int PW = tsp_pkg::PRESSURE_W;
  localparam int CW = tsp_pkg::COORD_W;

  // configuration registers
  logic signed [tsp_pkg::GAIN_W-1:0]   gain_x_rx_r, gain_x_ry_r;
  logic signed [tsp_pkg::GAIN_W-1:0]   gain_y_rx_r, gain_y_ry_r;
  logic signed [tsp_pkg::OFFSET_W-1:0] offset_x_r, offset_y_r;
  logic                                cal_valid_r;
  logic [PW-1:0]                       threshold_r;

  // pipeline stages
  logic              a_vld_r, b_vld_r, o_vld_r;
  tsp_pkg::status_t  a_status_r, b_status_r, o_status_r;
  tsp_pkg::status_t  a_status_nxt;
  logic [PW-1:0]     a_pressure_r, b_pressure_r, o_pressure_r;
  logic [PW-1:0]     a_pressure_nxt, pressure;
  logic [SW-1:0]     a_rx_r, a_ry_r;
  logic [SW:0]       sum_x, sum_y;
  logic [CW-1:0]     o_x_r, o_y_r;
  logic [CW-1:0]     map_x, map_y;
  logic              adv_a, adv_b, adv_o, in_xfer;

  // unpack input fields
  logic [SW-1:0] z1, z2, xa, xb, ya, yb;
  assign z1 = in_tdata[11:0];
  assign z2 = in_tdata[23:12];
  assign xa = in_tdata[35:24];
  assign xb = in_tdata[47:36];
  assign ya = in_tdata[59:48];
  assign yb = in_tdata[71:60];

  // stage advance: a stage loads when it is empty or its content moves on
  assign adv_o     = !o_vld_r || out_tready;
  assign adv_b     = !b_vld_r || adv_o;
  assign adv_a     = !a_vld_r || adv_b;
  assign in_tready = adv_a;
  assign in_xfer   = in_tvalid && in_tready;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_x_rx_r <= '0;
      gain_x_ry_r <= '0;
      offset_x_r  <= '0;
      gain_y_rx_r <= '0;
      gain_y_ry_r <= '0;
      offset_y_r  <= '0;
      cal_valid_r <= 1'b0;
      threshold_r <= tsp_pkg::THRESHOLD_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_addr)
        tsp_pkg::REG_GAIN_X_RX: gain_x_rx_r <= cfg_wdata[tsp_pkg::GAIN_W-1:0];
        tsp_pkg::REG_GAIN_X_RY: gain_x_ry_r <= cfg_wdata[tsp_pkg::GAIN_W-1:0];
        tsp_pkg::REG_OFFSET_X:  offset_x_r  <= cfg_wdata;
        tsp_pkg::REG_GAIN_Y_RX: gain_y_rx_r <= cfg_wdata[tsp_pkg::GAIN_W-1:0];
        tsp_pkg::REG_GAIN_Y_RY: gain_y_ry_r <= cfg_wdata[tsp_pkg::GAIN_W-1:0];
        tsp_pkg::REG_OFFSET_Y:  offset_y_r  <= cfg_wdata;
        tsp_pkg::REG_CAL_VALID: cal_valid_r <= cfg_wdata[0];
        tsp_pkg::REG_THRESHOLD: threshold_r <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  // gate on calibration, pen level and pressure
  always_comb begin
    pressure = PW'(z1) + tsp_pkg::Z_FULL_SCALE - PW'(z2);
    sum_x    = {1'b0, xa} + {1'b0, xb};
    sum_y    = {1'b0, ya} + {1'b0, yb};
    if (!cal_valid_r) begin
      a_status_nxt   = tsp_pkg::ST_NO_CAL;
      a_pressure_nxt = '0;
    end else if (in_tuser) begin
      a_status_nxt   = tsp_pkg::ST_NOT_PRESSED;
      a_pressure_nxt = '0;
    end else if (pressure < threshold_r) begin
      a_status_nxt   = tsp_pkg::ST_TOO_LIGHT;
      a_pressure_nxt = pressure;
    end else begin
      a_status_nxt   = tsp_pkg::ST_VALID;
      a_pressure_nxt = pressure;
    end
  end

  // valid bits of the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (adv_a) a_vld_r <= in_tvalid;
      if (adv_b) b_vld_r <= a_vld_r;
      if (adv_o) o_vld_r <= b_vld_r;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_status_r   <= a_status_nxt;
      a_pressure_r <= a_pressure_nxt;
      a_rx_r       <= sum_x[SW:1];
      a_ry_r       <= sum_y[SW:1];
    end
  end

  // product stage payload, products live in the axis maps
  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_status_r   <= a_status_r;
      b_pressure_r <= a_pressure_r;
    end
  end

  tsp_axis_map #(
    .LIMIT         (SCREEN_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_map_x (
    .clk     (clk),
    .prod_en (adv_b),
    .raw_x   (a_rx_r),
    .raw_y   (a_ry_r),
    .gain_rx (gain_x_rx_r),
    .gain_ry (gain_x_ry_r),
    .offset  (offset_x_r),
    .coord   (map_x)
  );

  tsp_axis_map #(
    .LIMIT         (SCREEN_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_map_y (
    .clk     (clk),
    .prod_en (adv_b),
    .raw_x   (a_rx_r),
    .raw_y   (a_ry_r),
    .gain_rx (gain_y_rx_r),
    .gain_ry (gain_y_ry_r),
    .offset  (offset_y_r),
    .coord   (map_y)
  );

  // output register, point fields zero unless the point is valid
  always_ff @(posedge clk) begin
    if (adv_o) begin
      o_status_r   <= b_status_r;
      o_pressure_r <= b_pressure_r;
      o_x_r        <= (b_status_r == tsp_pkg::ST_VALID) ? map_x : '0;
      o_y_r        <= (b_status_r == tsp_pkg::ST_VALID) ? map_y : '0;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {3'b000, o_y_r, o_x_r, o_pressure_r};

`ifndef SYNTH
  // point fields are cleared for every status but a valid point
  a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != tsp_pkg::ST_VALID) |-> out_tdata[36:13] == '0)
    else $error("screen point not cleared for a rejected sample");

  // pressure is reported only once the pressure gate was reached
  a_pressure_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == tsp_pkg::ST_NO_CAL ||
                    out_tuser == tsp_pkg::ST_NOT_PRESSED)) |-> out_tdata[12:0] == '0)
    else $error("pressure reported without a pressure check");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register empty");
`endif

endmodule
